/* design/spkt_pkg.sv */
package spkt_pkg;

    localparam int KEY_W        = 32;
    localparam int ADDR_W       = 32;
    localparam int REFS_W       = 16;
    localparam int SLOT_FIELD_W = 4;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    localparam logic [ADDR_W-1:0] REGION_TOP_RESET = 32'h8000_0000;

    typedef enum logic {
        CMD_GET     = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ATTACHED  = 3'd0,
        ST_CREATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_REL_USED  = 3'd4,
        ST_REL_FREED = 3'd5,
        ST_KEYZERO   = 3'd6,
        ST_COUNTFULL = 3'd7
    } t_status;

    typedef struct packed {
        t_cmd                    cmd;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ADDR_W-1:0]       page_addr;
    } t_rsp;

endpackage

/* design/shared_page_key_table.sv */
// Shared page key table.
// A request item (get or release of a keyed shared page) is accepted at a
// rising clock edge where start is high and busy is low. Busy never rises,
// so one item can be accepted in every cycle.
// The item is registered at acceptance, looked up against every slot in the
// next cycle, and its result is registered at the end of that cycle. The
// result appears on o_rsp with o_done high for exactly one cycle, once the
// item has passed the request register and the result register. Throughput
// is one item per cycle; a single lookup stage lies between those two
// registers, and the table is updated at the same edge that registers the
// result, so the next item always sees it.
// The receiver cannot stall; every result must be taken in its cycle.
// The region_top register is written through the cfg channel, which is
// always ready; it should be written only while no item is in flight.
// Reset frees every slot, sets region_top to 0x80000000 and drops any item
// in flight.
module shared_page_key_table #(
    parameter int SLOTS      = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  spkt_pkg::t_req             i_req,
    output logic                       busy,
    output logic                       o_done,
    output spkt_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_valid,
    input  logic [spkt_pkg::ADDR_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);

    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_EXT_W = (SLOT_W > spkt_pkg::SLOT_FIELD_W) ?
                                SLOT_W : spkt_pkg::SLOT_FIELD_W;

    logic [spkt_pkg::ADDR_W-1:0] r_region_top;
    logic                        r_req_vld;
    spkt_pkg::t_req              r_req;
    logic                        r_done;
    spkt_pkg::t_rsp              r_rsp;

    logic [SLOTS-1:0]            r_slot_valid;
    logic [spkt_pkg::KEY_W-1:0]  r_slot_key  [SLOTS];
    logic [spkt_pkg::REFS_W-1:0] r_slot_refs [SLOTS];

    logic [SLOTS-1:0]            hit_vec;
    logic [SLOTS-1:0]            free_vec;
    logic [SLOT_W-1:0]           hit_idx;
    logic [SLOT_W-1:0]           free_idx;
    logic [spkt_pkg::REFS_W-1:0] hit_refs;
    logic                        key_zero;

    logic                        upd_en;
    logic [SLOT_W-1:0]           upd_idx;
    logic                        n_valid;
    logic                        key_wr;
    logic [spkt_pkg::REFS_W-1:0] n_refs;
    logic                        ok;
    logic [SLOT_W-1:0]           rsp_idx;
    spkt_pkg::t_status           n_status;

    logic [SLOT_W:0]             slot_plus;
    logic [spkt_pkg::ADDR_W-1:0] page_off;
    logic [SLOT_EXT_W-1:0]       slot_ext;
    spkt_pkg::t_rsp              n_rsp;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i]  = r_slot_valid[i] && (r_slot_key[i] == $unsigned(r_req.key));
            free_vec[i] = !r_slot_valid[i];
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_refs = r_slot_refs[hit_idx];
    assign key_zero = (r_req.key == '0);

    always_comb begin
        upd_en   = 1'b0;
        upd_idx  = hit_idx;
        n_valid  = 1'b1;
        key_wr   = 1'b0;
        n_refs   = hit_refs;
        ok       = 1'b0;
        rsp_idx  = hit_idx;
        n_status = spkt_pkg::ST_KEYZERO;
        priority if (key_zero) begin
            n_status = spkt_pkg::ST_KEYZERO;
        end else if (r_req.cmd == spkt_pkg::CMD_GET) begin
            priority if (|hit_vec) begin
                if (hit_refs == spkt_pkg::REFS_MAX) begin
                    n_status = spkt_pkg::ST_COUNTFULL;
                end else begin
                    n_status = spkt_pkg::ST_ATTACHED;
                    upd_en   = 1'b1;
                    n_refs   = hit_refs + 1'b1;
                    ok       = 1'b1;
                end
            end else if (|free_vec) begin
                n_status = spkt_pkg::ST_CREATED;
                upd_en   = 1'b1;
                upd_idx  = free_idx;
                key_wr   = 1'b1;
                n_refs   = spkt_pkg::REFS_W'(1);
                ok       = 1'b1;
                rsp_idx  = free_idx;
            end else begin
                n_status = spkt_pkg::ST_FULL;
            end
        end else begin
            priority if (!(|hit_vec)) begin
                n_status = spkt_pkg::ST_NOTFOUND;
            end else if (hit_refs <= spkt_pkg::REFS_W'(1)) begin
                n_status = spkt_pkg::ST_REL_FREED;
                upd_en   = 1'b1;
                n_valid  = 1'b0;
                n_refs   = '0;
                ok       = 1'b1;
            end else begin
                n_status = spkt_pkg::ST_REL_USED;
                upd_en   = 1'b1;
                n_refs   = hit_refs - 1'b1;
                ok       = 1'b1;
            end
        end
    end

    assign slot_plus = {1'b0, rsp_idx} + 1'b1;
    assign page_off  = spkt_pkg::ADDR_W'(slot_plus) * spkt_pkg::ADDR_W'(PAGE_BYTES);
    assign slot_ext  = SLOT_EXT_W'(rsp_idx);

    always_comb begin
        n_rsp.status    = n_status;
        n_rsp.slot      = ok ? slot_ext[spkt_pkg::SLOT_FIELD_W-1:0] : '0;
        n_rsp.page_addr = ok ? (r_region_top - page_off) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_top <= spkt_pkg::REGION_TOP_RESET;
            r_req_vld    <= 1'b0;
            r_done       <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_region_top <= i_cfg_data;
            end
            r_req_vld <= start && !busy;
            r_done    <= r_req_vld;
            if (r_req_vld && upd_en) begin
                r_slot_valid[upd_idx] <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
        if (r_req_vld && upd_en) begin
            r_slot_refs[upd_idx] <= n_refs;
            if (key_wr) begin
                r_slot_key[upd_idx] <= $unsigned(r_req.key);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("Accepted item did not produce a result two cycles later.");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == spkt_pkg::ST_FULL ||
                    o_rsp.status == spkt_pkg::ST_NOTFOUND ||
                    o_rsp.status == spkt_pkg::ST_KEYZERO ||
                    o_rsp.status == spkt_pkg::ST_COUNTFULL))
        |-> (o_rsp.slot == '0 && o_rsp.page_addr == '0))
        else $error("Error result carries a nonzero slot or address.");

    a_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == spkt_pkg::ST_FULL) |-> (&r_slot_valid))
        else $error("Table full reported while a slot is free.");

    a_create : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == spkt_pkg::ST_CREATED && $past(i_rst_n))
        |-> ($countones(r_slot_valid) == $countones($past(r_slot_valid)) + 1))
        else $error("Created item did not claim exactly one slot.");

    a_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == spkt_pkg::ST_REL_FREED && $past(i_rst_n))
        |-> ($countones(r_slot_valid) + 1 == $countones($past(r_slot_valid))))
        else $error("Freed item did not release exactly one slot.");
`endif

endmodule
